[rtl/kcrs_pkg.sv]
package kcrs_pkg;

	localparam int BASE_W  = 2;
	localparam int KMER_W  = 64;
	localparam int MULT_W  = 32;
	localparam int SCORE_W = 6;
	localparam int LEN_W   = 6;
	localparam int MODE_W  = 2;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;
	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 56;

	localparam logic [BASE_W-1:0] BASE_A = 2'h0;
	localparam logic [BASE_W-1:0] BASE_C = 2'h1;
	localparam logic [BASE_W-1:0] BASE_T = 2'h2;
	localparam logic [BASE_W-1:0] BASE_G = 2'h3;

	localparam logic [MODE_W-1:0] MODE_GC = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GA = 2'd1;
	localparam logic [MODE_W-1:0] MODE_GT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SCORE_MODE    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LENGTH = 8'd1;

	// open runs of both letter pairs plus the scores so far
	typedef struct packed {
		logic [KMER_W-1:0]  kmer;
		logic [MULT_W-1:0]  mult;
		logic [SCORE_W-1:0] fwd;
		logic [SCORE_W-1:0] rev;
		logic [LEN_W-1:0]   f_run;
		logic               f_sa;
		logic               f_sb;
		logic [LEN_W-1:0]   r_run;
		logic               r_sa;
		logic               r_sb;
	} cell_state_t;

	typedef struct packed {
		logic [SCORE_W-1:0] fwd;
		logic [SCORE_W-1:0] rev;
		logic [SCORE_W-1:0] comb;
		logic [MULT_W-1:0]  mult;
	} result_t;

endpackage

[rtl/kcrs_cell.sv]
module kcrs_cell #(
	parameter int IDX = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic [kcrs_pkg::MODE_W-1:0] mode,
	input  logic [kcrs_pkg::LEN_W-1:0]  len_eff,
	input  logic                     in_valid,
	input  kcrs_pkg::cell_state_t    in_state,
	output logic                     out_valid,
	output kcrs_pkg::cell_state_t    out_state
);
	import kcrs_pkg::*;

	logic [BASE_W-1:0] b;
	logic              active;
	logic              in_f, f_first, r_first;
	cell_state_t       nxt;

	assign b      = in_state.kmer[2*IDX +: BASE_W];
	assign active = len_eff > LEN_W'(IDX);

	always_comb begin
		in_f    = 1'b0;
		f_first = 1'b0;
		r_first = 1'b0;
		case (mode)
			MODE_GA: begin
				in_f    = (b == BASE_A) || (b == BASE_G);
				f_first = (b == BASE_A);
				r_first = (b == BASE_T);
			end
			MODE_GT: begin
				in_f    = (b == BASE_G) || (b == BASE_T);
				f_first = (b == BASE_G);
				r_first = (b == BASE_A);
			end
			default: begin
				in_f    = 1'b0;
				f_first = 1'b0;
				r_first = 1'b0;
			end
		endcase
	end

	always_comb begin
		nxt = in_state;
		if (active) begin
			case (mode)
				MODE_GC: begin
					if (b == BASE_C || b == BASE_G)
						nxt.fwd = in_state.fwd + SCORE_W'(1);
					else
						nxt.rev = in_state.rev + SCORE_W'(1);
				end
				MODE_GA, MODE_GT: begin
					if (in_f) begin
						// extend forward run, close reverse run
						nxt.f_run = in_state.f_run + LEN_W'(1);
						nxt.f_sa  = in_state.f_sa | f_first;
						nxt.f_sb  = in_state.f_sb | ~f_first;
						if (in_state.r_sa && in_state.r_sb)
							nxt.rev = in_state.rev + SCORE_W'(in_state.r_run);
						nxt.r_run = '0;
						nxt.r_sa  = 1'b0;
						nxt.r_sb  = 1'b0;
					end else begin
						nxt.r_run = in_state.r_run + LEN_W'(1);
						nxt.r_sa  = in_state.r_sa | r_first;
						nxt.r_sb  = in_state.r_sb | ~r_first;
						if (in_state.f_sa && in_state.f_sb)
							nxt.fwd = in_state.fwd + SCORE_W'(in_state.f_run);
						nxt.f_run = '0;
						nxt.f_sa  = 1'b0;
						nxt.f_sb  = 1'b0;
					end
				end
				default: begin
					nxt = in_state;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_state <= nxt;
		end
	end

endmodule

[rtl/kcrs_out.sv]
module kcrs_out (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  kcrs_pkg::cell_state_t in_state,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output kcrs_pkg::result_t     out_res
);
	import kcrs_pkg::*;

	logic [SCORE_W-1:0] fwd_c, rev_c;
	result_t            res;
	result_t            out_q, skid_q;
	logic               out_v_q, skid_v_q;

	// close the runs still open at the end of the scan
	always_comb begin
		fwd_c = in_state.fwd;
		rev_c = in_state.rev;
		if (in_state.f_sa && in_state.f_sb)
			fwd_c = in_state.fwd + SCORE_W'(in_state.f_run);
		if (in_state.r_sa && in_state.r_sb)
			rev_c = in_state.rev + SCORE_W'(in_state.r_run);
		res.fwd  = fwd_c;
		res.rev  = rev_c;
		res.comb = (fwd_c > rev_c) ? fwd_c : rev_c;
		res.mult = in_state.mult;
	end

	assign in_ready  = ~skid_v_q;
	assign out_valid = out_v_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			if (!out_v_q || out_ready)
				out_v_q <= 1'b1;
			else
				skid_v_q <= 1'b1;
		end else if (out_v_q && out_ready) begin
			if (skid_v_q)
				skid_v_q <= 1'b0;
			else
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			if (!out_v_q || out_ready)
				out_q <= res;
			else
				skid_q <= res;
		end else if (out_v_q && out_ready && skid_v_q) begin
			out_q <= skid_q;
		end
	end

endmodule

[rtl/kmer_composition_repeat_scorer.sv]
// channel | direction | tdata / data fields (low bit up)
// s       | in        | kmer_bases[63:0], multiplicity[95:64]
// m       | out       | forward_score[5:0], reverse_score[11:6], combined_score[17:12],
//         |           | multiplicity_out[49:18], zero pad [55:50]
// cfg     | in        | cfg_index: 0 score_mode, 1 active_length; cfg_data low bits
//
// One k-mer per cycle sustained while the output is not stalled. A row of
// MAX_BASES cells, one per base, each holding one stage of the scan; a result
// passes the cell registers in order and is then loaded into the output
// register. Reset clears valid flags and sets score_mode 0, active_length 32.
// A stalled output fills a skid register; the whole row and the input then
// hold until the skid register drains.
module kmer_composition_repeat_scorer #(
	parameter int MAX_BASES = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [kcrs_pkg::IN_DATA_W-1:0]     s_tdata,  // kmer_bases, multiplicity
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [kcrs_pkg::OUT_DATA_W-1:0]    m_tdata,  // fwd, rev, comb, mult, pad
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [kcrs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [kcrs_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import kcrs_pkg::*;

	logic [MODE_W-1:0] mode_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  len_eff;
	logic              en;

	logic        vld [0:MAX_BASES];
	cell_state_t st  [0:MAX_BASES];
	result_t     res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_GC;
			len_q  <= LEN_W'(32);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_SCORE_MODE)
				mode_q <= cfg_data[MODE_W-1:0];
			else if (cfg_index == REG_ACTIVE_LENGTH)
				len_q <= cfg_data[LEN_W-1:0];
		end
	end

	assign len_eff = (len_q > LEN_W'(MAX_BASES)) ? LEN_W'(MAX_BASES) : len_q;

	assign s_tready = en;

	// scores, runs and flags start cleared
	assign vld[0] = s_tvalid;
	assign st[0]  = {s_tdata[KMER_W-1:0], s_tdata[KMER_W +: MULT_W],
		{(2*SCORE_W + 2*LEN_W + 4){1'b0}}};

	for (genvar i = 0; i < MAX_BASES; i++) begin : g_cell
		kcrs_cell #(
			.IDX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.mode     (mode_q),
			.len_eff  (len_eff),
			.in_valid (vld[i]),
			.in_state (st[i]),
			.out_valid(vld[i+1]),
			.out_state(st[i+1])
		);
	end

	kcrs_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld[MAX_BASES]),
		.in_state (st[MAX_BASES]),
		.in_ready (en),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (res)
	);

	assign m_tdata = {{(OUT_DATA_W - 3*SCORE_W - MULT_W){1'b0}},
		res.mult, res.comb, res.rev, res.fwd};

endmodule

[tb/kmer_composition_repeat_scorer_tb.sv]
module kmer_composition_repeat_scorer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kcrs_pkg::*;

	localparam int MAX_K    = 32;
	localparam int LATENCY  = MAX_K + 1;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	// m_tdata field offsets
	localparam int FWD_LSB  = 0;
	localparam int REV_LSB  = 6;
	localparam int COMB_LSB = 12;
	localparam int MULT_LSB = 18;
	localparam int PAD_LSB  = 50;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // kmer_bases[63:0], multiplicity[95:64]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // fwd[5:0], rev[11:6], comb[17:12], mult[49:18], pad
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	kmer_composition_repeat_scorer #(.MAX_BASES(MAX_K)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow of the block's registers
	logic [MODE_W-1:0] cur_mode;
	logic [LEN_W-1:0]  cur_len;

	result_t expected_scores[$];
	int n_kmers;
	int n_scores;
	int n_errors;
	int n_cfg_writes;
	bit quiet;       // no idling on either side
	int recv_wait;
	int hold_left;

	initial begin
		clk = 1'b0;
	end
	always #5 clk = ~clk;

	function automatic result_t score_kmer(input logic [MODE_W-1:0] mode,
			input logic [LEN_W-1:0] len_reg, input logic [KMER_W-1:0] kmer,
			input logic [MULT_W-1:0] mult);
		int n;
		int fwd;
		int rev;
		int f_run;
		int r_run;
		bit f_a, f_b, r_a, r_b;
		logic [BASE_W-1:0] f_x, f_y, r_x, r_y, b;
		result_t res;
		n = (len_reg > MAX_K) ? MAX_K : int'(len_reg);
		fwd = 0;
		rev = 0;
		f_run = 0;
		r_run = 0;
		f_a = 0; f_b = 0; r_a = 0; r_b = 0;
		if (mode == MODE_GA) begin
			f_x = BASE_A; f_y = BASE_G; r_x = BASE_T; r_y = BASE_C;
		end else begin
			f_x = BASE_G; f_y = BASE_T; r_x = BASE_A; r_y = BASE_C;
		end
		if (mode == MODE_GC) begin
			for (int i = 0; i < n; i++) begin
				b = kmer[2*i +: 2];
				if (b == BASE_C || b == BASE_G)
					fwd++;
				else
					rev++;
			end
		end else if (mode == MODE_GA || mode == MODE_GT) begin
			// the two pairs split the alphabet: a base of one pair closes the other's run
			for (int i = 0; i < n; i++) begin
				b = kmer[2*i +: 2];
				if (b == f_x || b == f_y) begin
					if (b == f_x) f_a = 1; else f_b = 1;
					f_run++;
					if (r_a && r_b) rev += r_run;
					r_run = 0; r_a = 0; r_b = 0;
				end else begin
					if (b == r_x) r_a = 1; else r_b = 1;
					r_run++;
					if (f_a && f_b) fwd += f_run;
					f_run = 0; f_a = 0; f_b = 0;
				end
			end
			if (f_a && f_b) fwd += f_run;
			if (r_a && r_b) rev += r_run;
		end
		res.fwd  = fwd[SCORE_W-1:0];
		res.rev  = rev[SCORE_W-1:0];
		res.comb = (fwd > rev) ? fwd[SCORE_W-1:0] : rev[SCORE_W-1:0];
		res.mult = mult;
		return res;
	endfunction

	// mostly alternating runs of one letter pair or the other, some noise
	function automatic logic [KMER_W-1:0] rand_kmer();
		logic [KMER_W-1:0] k;
		logic [BASE_W-1:0] b;
		bit fam;
		bit side;
		bit pick;
		k = {$urandom, $urandom};
		if ($urandom_range(0, 3) != 0) begin
			fam = 1'($urandom_range(0, 1));
			side = 1'($urandom_range(0, 1));
			for (int i = 0; i < MAX_K; i++) begin
				if ($urandom_range(0, 4) == 0) side = ~side;
				pick = 1'($urandom_range(0, 1));
				case ({fam, side})
					2'b00: b = pick ? BASE_G : BASE_A;
					2'b01: b = pick ? BASE_C : BASE_T;
					2'b10: b = pick ? BASE_T : BASE_G;
					default: b = pick ? BASE_C : BASE_A;
				endcase
				if ($urandom_range(0, 15) == 0) b = BASE_W'($urandom_range(0, 3));
				k[2*i +: 2] = b;
			end
		end
		return k;
	endfunction

	function automatic logic [MULT_W-1:0] rand_mult();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return $urandom;
	endfunction

	// result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			n_scores++;
			recv_wait = quiet ? 0 : $urandom_range(0, 8);
			if (expected_scores.size() == 0) begin
				$error("unexpected result transfer: tdata %h", m_tdata);
				n_errors++;
			end else begin
				want = expected_scores.pop_front();
				if (m_tdata[FWD_LSB +: SCORE_W] !== want.fwd) begin
					$error("forward_score: expected %0d, got %0d", want.fwd,
						m_tdata[FWD_LSB +: SCORE_W]);
					n_errors++;
				end
				if (m_tdata[REV_LSB +: SCORE_W] !== want.rev) begin
					$error("reverse_score: expected %0d, got %0d", want.rev,
						m_tdata[REV_LSB +: SCORE_W]);
					n_errors++;
				end
				if (m_tdata[COMB_LSB +: SCORE_W] !== want.comb) begin
					$error("combined_score: expected %0d, got %0d", want.comb,
						m_tdata[COMB_LSB +: SCORE_W]);
					n_errors++;
				end
				if (m_tdata[MULT_LSB +: MULT_W] !== want.mult) begin
					$error("multiplicity_out: expected %h, got %h", want.mult,
						m_tdata[MULT_LSB +: MULT_W]);
					n_errors++;
				end
				if (m_tdata[OUT_DATA_W-1:PAD_LSB] !== '0) begin
					$error("pad: expected 0, got %h", m_tdata[OUT_DATA_W-1:PAD_LSB]);
					n_errors++;
				end
			end
		end
	end

	// result receiver: per-result wait, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (recv_wait > 0) begin
			m_tready <= 1'b0;
			recv_wait = recv_wait - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_kmer(input logic [KMER_W-1:0] kmer, input logic [MULT_W-1:0] mult);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 8);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {mult, kmer};
		do @(posedge clk); while (!s_tready);
		expected_scores = {expected_scores, score_kmer(cur_mode, cur_len, kmer, mult)};
		n_kmers++;
	endtask

	// stop offering, then wait out every pending result and the pipeline depth
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_scores.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_SCORE_MODE)
			cur_mode = data[MODE_W-1:0];
		else if (idx == REG_ACTIVE_LENGTH)
			cur_len = data[LEN_W-1:0];
		n_cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_gc_counts();
		write_reg(REG_SCORE_MODE, MODE_GC);
		write_reg(REG_ACTIVE_LENGTH, 8'd32);
		send_kmer(64'h0, 32'h0);
		send_kmer('1, '1);
		send_kmer(64'h5555_5555_5555_5555, 32'h1);
		send_kmer(64'hAAAA_AAAA_AAAA_AAAA, 32'h8000_0000);
		send_kmer(64'h0123_4567_89AB_CDEF, 32'h1234_5678);
		settle();
	endtask

	task automatic test_repeat_modes();
		write_reg(REG_SCORE_MODE, MODE_GA);
		send_kmer(64'hCCCC_CCCC_CCCC_CCCC, 32'h7);   // AGAG...
		send_kmer(64'h6666_6666_6666_6666, 32'h8);   // TCTC...
		send_kmer(64'h0, 32'h9);                     // A only, never scores
		send_kmer(64'hCCCC_0000_6666_CCCC, 32'hA);
		settle();
		write_reg(REG_SCORE_MODE, MODE_GT);
		send_kmer(64'hBBBB_BBBB_BBBB_BBBB, 32'hB);   // GTGT...
		send_kmer(64'h4444_4444_4444_4444, 32'hC);   // ACAC...
		send_kmer(64'hBBBB_4444_BBBB_4444, 32'hD);
		settle();
	endtask

	task automatic test_odd_settings();
		// upper data bits dropped: selects the unused mode
		write_reg(REG_SCORE_MODE, 8'hFF);
		send_kmer(64'hCCCC_CCCC_CCCC_CCCC, 32'hDEAD_BEEF);
		settle();
		write_reg(REG_SCORE_MODE, MODE_GC);
		write_reg(REG_ACTIVE_LENGTH, 8'd0);
		send_kmer('1, 32'h11);
		settle();
		write_reg(REG_ACTIVE_LENGTH, 8'd1);
		send_kmer(64'hFFFF_FFFF_FFFF_FFFC, 32'h22);
		settle();
		write_reg(REG_ACTIVE_LENGTH, 8'd63);
		send_kmer(64'h0123_4567_89AB_CDEF, 32'h33);
		settle();
		write_reg(REG_ACTIVE_LENGTH, 8'd33);
		send_kmer(64'hFFFF_0000_FFFF_0000, 32'h44);
		settle();
		write_reg(REG_ACTIVE_LENGTH, 8'hC4);
		send_kmer(64'h0000_0000_0000_00FF, 32'h55);
		settle();
		// writes to unmapped indexes leave both registers alone
		write_reg(REG_ACTIVE_LENGTH + 8'd1, 8'd2);
		write_reg('1, 8'd1);
		send_kmer(64'h0000_0000_0000_00FF, 32'h66);
		settle();
		// bases above the active length are ignored
		write_reg(REG_SCORE_MODE, MODE_GA);
		send_kmer(64'hFFFF_FFFF_FFFF_FFCC, 32'h77);
		settle();
	endtask

	task automatic test_backpressure();
		write_reg(REG_SCORE_MODE, MODE_GT);
		write_reg(REG_ACTIVE_LENGTH, 8'd32);
		quiet = 1;
		@(posedge clk);
		hold_left = 300;
		repeat (100) send_kmer(rand_kmer(), rand_mult());
		quiet = 0;
		settle();
	endtask

	task automatic test_random();
		int n_items;
		int r;
		logic [LEN_W-1:0] len;
		logic [MODE_W-1:0] mode;
		for (int phase = 0; phase < 9; phase++) begin
			mode = ($urandom_range(0, 9) == 0) ? MODE_UNUSED : MODE_W'($urandom_range(0, 2));
			r = $urandom_range(0, 9);
			if (phase == 0 || r == 7)
				len = 6'd32;
			else if (phase == 1 || r == 6)
				len = 6'd1;
			else if (r == 8)
				len = LEN_W'($urandom_range(33, 63));
			else if (r == 9)
				len = 6'd0;
			else
				len = LEN_W'($urandom_range(1, 32));
			write_reg(REG_SCORE_MODE, {6'($urandom_range(0, 63)), mode});
			write_reg(REG_ACTIVE_LENGTH,
				($urandom_range(0, 3) == 0) ? {2'($urandom_range(0, 3)), len}
					: {2'b00, len});
			if ($urandom_range(0, 2) == 0)
				write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
			quiet = (phase % 3 == 2);
			n_items = $urandom_range(80, 140);
			repeat (n_items) send_kmer(rand_kmer(), rand_mult());
			quiet = 0;
			settle();
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		cur_mode  = MODE_GC;
		cur_len   = 6'd32;
		n_kmers   = 0;
		n_scores  = 0;
		n_errors  = 0;
		n_cfg_writes = 0;
		quiet     = 0;
		recv_wait = 0;
		hold_left = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		// reset values in effect before any write
		send_kmer(64'h0123_4567_89AB_CDEF, 32'hCAFE_F00D);
		settle();
		test_gc_counts();
		test_repeat_modes();
		test_odd_settings();
		test_backpressure();
		test_random();
		settle();

		$display("tb: %0d k-mers scored, %0d results checked, %0d register writes",
			n_kmers, n_scores, n_cfg_writes);
		$display("tb: covered GC, GA and GT modes, unused mode, zero and clamped lengths, stalls");
		if (n_errors == 0 && expected_scores.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
